// ----- rtl/sstr_pkg.sv -----
// ----------------------------------------------------------------------------
// sstr_pkg
// Shared types and constants for the supersampled triangle rasteriser.
// ----------------------------------------------------------------------------
package sstr_pkg;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ORIENT,
        ST_BOX,
        ST_SETUP,
        ST_SCAN,
        ST_MUL,
        ST_CLAMP,
        ST_DIV,
        ST_WRITE,
        ST_POINT,
        ST_RD,
        ST_ACC
    } state_t;

    // Command codes
    localparam logic [2:0] CMD_CLEAR   = 3'd0;
    localparam logic [2:0] CMD_FLAT    = 3'd1;
    localparam logic [2:0] CMD_INTERP  = 3'd2;
    localparam logic [2:0] CMD_POINT   = 3'd3;
    localparam logic [2:0] CMD_RESOLVE = 3'd4;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RATE   = 2'd2;

    // Datapath widths, sized for the full parameter range
    localparam int MUL_W  = 24;
    localparam int EDGE_W = 2 * MUL_W;
    localparam int BARY_W = EDGE_W + 2;
    localparam int NUM_W  = BARY_W + 12;
    localparam int DIV_W  = 56;

    localparam logic [23:0] WHITE = 24'hFFFFFF;

endpackage

// ----- rtl/supersampled_triangle_rasterizer_top.sv -----
// ----------------------------------------------------------------------------
// supersampled_triangle_rasterizer_top
// Supersampled colour store with clear, point, triangle and resolve commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; only a resolve gives
// a result, shown for exactly one cycle with done high, and the receiver
// cannot stall it. All samples sit in one single-port synchronous memory.
// After reset, a clear command or a write to the width, height or rate
// register, the block sweeps the whole store to white, one sample a cycle,
// with busy high; the store holds MAX_WIDTH*MAX_HEIGHT*MAX_ROOT_RATE^2
// samples, 65536 at the defaults. A triangle is set up on a shared 24x24
// multiplier, then every sample of its clipped bounding box is visited; when
// colours are interpolated, each covered sample takes 8 shift-add steps, a
// clamp, 8 divide steps and the write. A point writes all root_rate^2 samples
// of a pixel; a resolve sums them, divides in 8 steps, or is zero off screen.
// ----------------------------------------------------------------------------
module supersampled_triangle_rasterizer_top #(
    parameter int MAX_WIDTH     = 64,
    parameter int MAX_HEIGHT    = 64,
    parameter int MAX_ROOT_RATE = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         cmd,
    input  logic signed [15:0] v0_x,
    input  logic signed [15:0] v0_y,
    input  logic signed [15:0] v1_x,
    input  logic signed [15:0] v1_y,
    input  logic signed [15:0] v2_x,
    input  logic signed [15:0] v2_y,
    input  logic [23:0]        color_a,
    input  logic [23:0]        color_b,
    input  logic [23:0]        color_c,
    input  logic [5:0]         pixel_x,
    input  logic [5:0]         pixel_y,
    output logic               done,
    output logic [7:0]         red,
    output logic [7:0]         green,
    output logic [7:0]         blue
);
    import sstr_pkg::*;

    localparam int SLOTS = MAX_ROOT_RATE * MAX_ROOT_RATE;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * SLOTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int SW    = (MAX_ROOT_RATE > 1) ? $clog2(MAX_ROOT_RATE) : 1;
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int SUM_W = 8 + CW;

    // Configuration and control state
    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_cnt_reg;
    logic              done_reg;
    logic [6:0]        actw_reg, acth_reg;
    logic [2:0]        root_reg;

    // Command operands
    logic signed [15:0] vx_reg [3];
    logic signed [15:0] vy_reg [3];
    logic [23:0]        col_reg [3];
    logic               interp_reg;
    logic               res_mode_reg;

    // Set-up datapath
    logic [3:0]                step_reg;
    logic signed [MUL_W-1:0]   op_a, op_b;
    logic signed [EDGE_W-1:0]  prod_reg, first_reg, sum_now;
    logic signed [MUL_W-1:0]   px_reg [3];
    logic signed [MUL_W-1:0]   py_reg [3];
    logic signed [MUL_W-1:0]   ex_reg [3];
    logic signed [MUL_W-1:0]   ey_reg [3];
    logic signed [EDGE_W-1:0]  d_reg, dd_reg;

    // Traversal
    logic [XW-1:0]             x0_reg, x1_reg, cx_reg;
    logic [YW-1:0]             y0_reg, y1_reg, cy_reg;
    logic [SW-1:0]             ci_reg, cj_reg;
    logic signed [EDGE_W-1:0]  ecur_reg [3];
    logic signed [EDGE_W-1:0]  erow_reg [3];
    logic signed [EDGE_W-1:0]  vncur_reg, vnrow_reg;

    // Blend and divide
    logic signed [BARY_W-1:0]  u_reg, v_reg, w_reg;
    logic signed [NUM_W-1:0]   acc_reg [3];
    logic [2:0]                mb_reg, db_reg;
    logic [DIV_W-1:0]          rem_reg [3];
    logic [DIV_W-1:0]          dsh_reg;
    logic [7:0]                q_reg [3];
    logic [7:0]                q_next [3];
    logic [DIV_W-1:0]          rem_next [3];

    // Point and resolve
    logic [CW-1:0]             s_reg;
    logic [SUM_W-1:0]          sum_reg [3];
    logic [SUM_W-1:0]          sum_next [3];
    logic [7:0]                red_reg, green_reg, blue_reg;

    // Memory port
    logic [23:0]               mem [DEPTH];
    logic [23:0]               rdata_reg;
    logic                      mem_we;
    logic [AW-1:0]             mem_addr;
    logic [23:0]               mem_wdata;

    // Combinational helpers
    logic                      cfg_hit, accept, pt_ok, res_ok, box_ok;
    logic                      covered, blend_en, col_last, row_last, adv_done;
    logic [CW-1:0]             cnt, slot_tri;
    logic signed [15:0]        lox, hix, loy, hiy;
    logic signed [16:0]        limx, limy;
    logic signed [MUL_W-1:0]   px_c [3];
    logic signed [MUL_W-1:0]   py_c [3];
    logic signed [MUL_W-1:0]   sx0, sy0;
    logic [MUL_W-1:0]          sx0_u, sy0_u;
    logic signed [EDGE_W-1:0]  colstep [3];
    logic signed [EDGE_W-1:0]  rowstep [3];
    logic signed [EDGE_W-1:0]  ecur_adv [3];
    logic signed [EDGE_W-1:0]  erow_adv [3];
    logic signed [EDGE_W-1:0]  vncur_adv, vnrow_adv;
    logic [XW-1:0]             cx_adv;
    logic [YW-1:0]             cy_adv;
    logic [SW-1:0]             ci_adv, cj_adv;
    logic signed [EDGE_W-1:0]  vn_s, wn_s;
    logic signed [NUM_W-1:0]   lim_n;

    // One colour channel, red first
    function automatic logic [7:0] chan(input logic [23:0] c, input int ch);
        logic [7:0] r;
        case (ch)
            0:       r = c[23:16];
            1:       r = c[15:8];
            default: r = c[7:0];
        endcase
        return r;
    endfunction

    // One bit of one colour channel
    function automatic logic chan_bit(input logic [23:0] c, input int ch,
                                      input logic [2:0] b);
        logic [7:0] r;
        r = chan(c, ch);
        return r[b];
    endfunction

    // Sample address of pixel (x, y), slot s
    function automatic logic [AW-1:0] addr_of(input logic [XW-1:0] x,
                                              input logic [YW-1:0] y,
                                              input logic [CW-1:0] s);
        return AW'((AW'(y) * AW'(MAX_WIDTH) + AW'(x)) * AW'(SLOTS) + AW'(s));
    endfunction

    // Register write saturation
    function automatic logic [6:0] sat7(input logic [6:0] v, input int hi);
        logic [6:0] r;
        if (v == 7'd0)
            r = 7'd1;
        else if (int'(v) > hi)
            r = 7'(hi);
        else
            r = v;
        return r;
    endfunction

    assign pready  = 1'b1;
    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign cfg_hit = psel && penable && pwrite &&
                     (paddr[3:2] == REG_WIDTH || paddr[3:2] == REG_HEIGHT ||
                      paddr[3:2] == REG_RATE);
    assign done    = done_reg;
    assign red     = red_reg;
    assign green   = green_reg;
    assign blue    = blue_reg;

    // Register read-back
    always_comb
    begin
        unique case (paddr[3:2])
            REG_WIDTH:  prdata = {25'd0, actw_reg};
            REG_HEIGHT: prdata = {25'd0, acth_reg};
            REG_RATE:   prdata = {29'd0, root_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // Command qualification
    assign cnt    = CW'(root_reg) * CW'(root_reg);
    assign pt_ok  = !v0_x[15] && !v0_y[15] &&
                    (v0_x[15:4] < {5'd0, actw_reg}) && (v0_y[15:4] < {5'd0, acth_reg});
    assign res_ok = ({1'b0, pixel_x} < actw_reg) && ({1'b0, pixel_y} < acth_reg);

    // Bounding box and scaled vertices
    always_comb
    begin
        lox = vx_reg[0]; hix = vx_reg[0];
        loy = vy_reg[0]; hiy = vy_reg[0];
        for (int n = 1; n < 3; n++)
        begin
            if (vx_reg[n] < lox) lox = vx_reg[n];
            if (vx_reg[n] > hix) hix = vx_reg[n];
            if (vy_reg[n] < loy) loy = vy_reg[n];
            if (vy_reg[n] > hiy) hiy = vy_reg[n];
        end
        limx   = $signed({6'd0, actw_reg, 4'd0});
        limy   = $signed({6'd0, acth_reg, 4'd0});
        box_ok = !(17'(lox) >= limx) && !hix[15] && !(17'(loy) >= limy) && !hiy[15];
        for (int n = 0; n < 3; n++)
        begin
            px_c[n] = MUL_W'(vx_reg[n]) * MUL_W'($signed({1'b0, root_reg, 1'b0}));
            py_c[n] = MUL_W'(vy_reg[n]) * MUL_W'($signed({1'b0, root_reg, 1'b0}));
        end
    end

    // First sample centre of the box on the fine grid
    assign sx0_u = ((MUL_W'(root_reg) * MUL_W'(x0_reg)) << 5) + MUL_W'(16);
    assign sy0_u = ((MUL_W'(root_reg) * MUL_W'(y0_reg)) << 5) + MUL_W'(16);
    assign sx0   = $signed(sx0_u);
    assign sy0   = $signed(sy0_u);

    // Shared multiplier operands for orientation and edge set-up
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        if (state_reg == ST_ORIENT)
        begin
            case (step_reg)
                4'd0:
                begin
                    op_a = MUL_W'(vy_reg[0]) - MUL_W'(vy_reg[1]);
                    op_b = MUL_W'(vx_reg[0]) - MUL_W'(vx_reg[2]);
                end
                4'd1:
                begin
                    op_a = MUL_W'(vx_reg[1]) - MUL_W'(vx_reg[0]);
                    op_b = MUL_W'(vy_reg[0]) - MUL_W'(vy_reg[2]);
                end
                default: ;
            endcase
        end
        else if (state_reg == ST_SETUP)
        begin
            case (step_reg)
                4'd0: begin op_a = ex_reg[2];          op_b = ey_reg[0];  end
                4'd1: begin op_a = -ex_reg[0];         op_b = ey_reg[2];  end
                4'd2: begin op_a = sx0 - px_reg[0];    op_b = -ey_reg[0]; end
                4'd3: begin op_a = sy0 - py_reg[0];    op_b = ex_reg[0];  end
                4'd4: begin op_a = sx0 - px_reg[1];    op_b = -ey_reg[1]; end
                4'd5: begin op_a = sy0 - py_reg[1];    op_b = ex_reg[1];  end
                4'd6: begin op_a = sx0 - px_reg[2];    op_b = -ey_reg[2]; end
                4'd7: begin op_a = sy0 - py_reg[2];    op_b = ex_reg[2];  end
                4'd8: begin op_a = sy0 - py_reg[0];    op_b = ex_reg[2];  end
                4'd9: begin op_a = sx0 - px_reg[0];    op_b = -ey_reg[2]; end
                default: ;
            endcase
        end
    end

    assign sum_now = first_reg + prod_reg;

    // Coverage and traversal stepping
    always_comb
    begin
        covered  = !ecur_reg[0][EDGE_W-1] && !ecur_reg[1][EDGE_W-1] &&
                   !ecur_reg[2][EDGE_W-1];
        blend_en = interp_reg && (d_reg != '0);
        col_last = (3'(ci_reg) == root_reg - 3'd1) && (cx_reg == x1_reg);
        row_last = (3'(cj_reg) == root_reg - 3'd1) && (cy_reg == y1_reg);
        adv_done = col_last && row_last;
        slot_tri = CW'(root_reg) * CW'(ci_reg) + CW'(cj_reg);
        for (int n = 0; n < 3; n++)
        begin
            colstep[n] = -(EDGE_W'(ey_reg[n]) <<< 5);
            rowstep[n] = EDGE_W'(ex_reg[n]) <<< 5;
        end
        cx_adv = cx_reg;
        cy_adv = cy_reg;
        ci_adv = ci_reg;
        cj_adv = cj_reg;
        for (int n = 0; n < 3; n++)
        begin
            erow_adv[n] = erow_reg[n];
            ecur_adv[n] = ecur_reg[n] + colstep[n];
        end
        vnrow_adv = vnrow_reg;
        vncur_adv = vncur_reg + colstep[2];
        if (!col_last)
        begin
            if (3'(ci_reg) == root_reg - 3'd1)
            begin
                ci_adv = '0;
                cx_adv = cx_reg + XW'(1);
            end
            else
                ci_adv = ci_reg + SW'(1);
        end
        else
        begin
            ci_adv = '0;
            cx_adv = x0_reg;
            for (int n = 0; n < 3; n++)
            begin
                erow_adv[n] = erow_reg[n] + rowstep[n];
                ecur_adv[n] = erow_adv[n];
            end
            vnrow_adv = vnrow_reg + rowstep[2];
            vncur_adv = vnrow_adv;
            if (3'(cj_reg) == root_reg - 3'd1)
            begin
                cj_adv = '0;
                cy_adv = cy_reg + YW'(1);
            end
            else
                cj_adv = cj_reg + SW'(1);
        end
        // Barycentric weights with the area made positive
        vn_s  = d_reg[EDGE_W-1] ? -vncur_reg : vncur_reg;
        wn_s  = d_reg[EDGE_W-1] ? -ecur_reg[0] : ecur_reg[0];
        lim_n = (NUM_W'(dd_reg) <<< 8) - NUM_W'(dd_reg);
    end

    // Restoring divide step and resolve accumulation
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (rem_reg[c] >= dsh_reg)
            begin
                rem_next[c] = rem_reg[c] - dsh_reg;
                q_next[c]   = {q_reg[c][6:0], 1'b1};
            end
            else
            begin
                rem_next[c] = rem_reg[c];
                q_next[c]   = {q_reg[c][6:0], 1'b0};
            end
            sum_next[c] = sum_reg[c] + SUM_W'(chan(rdata_reg, c));
        end
    end

    // Next state and memory port
    always_comb
    begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_wdata  = col_reg[0];
        if (state_reg == ST_POINT || state_reg == ST_RD)
            mem_addr = addr_of(cx_reg, cy_reg, s_reg);
        else
            mem_addr = addr_of(cx_reg, cy_reg, slot_tri);
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_cnt_reg;
                mem_wdata = WHITE;
                if (clr_cnt_reg == AW'(DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd)
                        CMD_CLEAR:             state_next = ST_CLEAR;
                        CMD_FLAT, CMD_INTERP:  state_next = ST_ORIENT;
                        CMD_POINT:             if (pt_ok) state_next = ST_POINT;
                        CMD_RESOLVE:           if (res_ok) state_next = ST_RD;
                        default: ;
                    endcase
                end
            end
            ST_ORIENT:
                if (step_reg == 4'd2) state_next = ST_BOX;
            ST_BOX:
                state_next = box_ok ? ST_SETUP : ST_IDLE;
            ST_SETUP:
                if (step_reg == 4'd10) state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (covered && blend_en)
                    state_next = ST_MUL;
                else
                begin
                    mem_we = covered;
                    if (adv_done) state_next = ST_IDLE;
                end
            end
            ST_MUL:
                if (mb_reg == 3'd0) state_next = ST_CLAMP;
            ST_CLAMP:
                state_next = ST_DIV;
            ST_DIV:
                if (db_reg == 3'd0) state_next = res_mode_reg ? ST_IDLE : ST_WRITE;
            ST_WRITE:
            begin
                mem_we     = 1'b1;
                mem_wdata  = {q_reg[0], q_reg[1], q_reg[2]};
                state_next = adv_done ? ST_IDLE : ST_SCAN;
            end
            ST_POINT:
            begin
                mem_we = 1'b1;
                if (s_reg == cnt - CW'(1)) state_next = ST_IDLE;
            end
            ST_RD:
                state_next = ST_ACC;
            ST_ACC:
                state_next = (s_reg == cnt - CW'(1)) ? ST_DIV : ST_RD;
            default:
                state_next = ST_IDLE;
        endcase
        if (cfg_hit)
            state_next = ST_CLEAR;
    end

    // Sample store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rdata_reg <= mem[mem_addr];
    end

    // Control state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
            actw_reg    <= sat7(7'd64, MAX_WIDTH);
            acth_reg    <= sat7(7'd64, MAX_HEIGHT);
            root_reg    <= 3'd1;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (accept && cmd == CMD_RESOLVE && !res_ok) ||
                         (state_reg == ST_DIV && db_reg == 3'd0 && res_mode_reg);
            if (cfg_hit || (accept && cmd == CMD_CLEAR))
                clr_cnt_reg <= '0;
            else if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (psel && penable && pwrite)
            begin
                case (paddr[3:2])
                    REG_WIDTH:  actw_reg <= sat7(pwdata[6:0], MAX_WIDTH);
                    REG_HEIGHT: acth_reg <= sat7(pwdata[6:0], MAX_HEIGHT);
                    REG_RATE:   root_reg <= 3'(sat7({4'd0, pwdata[2:0]}, MAX_ROOT_RATE));
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    vx_reg[0]    <= v0_x; vx_reg[1] <= v1_x; vx_reg[2] <= v2_x;
                    vy_reg[0]    <= v0_y; vy_reg[1] <= v1_y; vy_reg[2] <= v2_y;
                    col_reg[0]   <= color_a;
                    col_reg[1]   <= color_b;
                    col_reg[2]   <= color_c;
                    interp_reg   <= (cmd == CMD_INTERP);
                    res_mode_reg <= (cmd == CMD_RESOLVE);
                    step_reg     <= '0;
                    s_reg        <= '0;
                    for (int c = 0; c < 3; c++)
                        sum_reg[c] <= '0;
                    if (cmd == CMD_POINT)
                    begin
                        cx_reg <= XW'(v0_x[15:4]);
                        cy_reg <= YW'(v0_y[15:4]);
                    end
                    else
                    begin
                        cx_reg <= XW'(pixel_x);
                        cy_reg <= YW'(pixel_y);
                    end
                    if (cmd == CMD_RESOLVE && !res_ok)
                    begin
                        red_reg   <= 8'd0;
                        green_reg <= 8'd0;
                        blue_reg  <= 8'd0;
                    end
                end
            end
            ST_ORIENT:
            begin
                step_reg <= step_reg + 4'd1;
                if (step_reg[0])
                    first_reg <= prod_reg;
                // Make the winding counter-clockwise
                if (step_reg == 4'd2 && sum_now > 0)
                begin
                    vx_reg[1]  <= vx_reg[2];  vx_reg[2]  <= vx_reg[1];
                    vy_reg[1]  <= vy_reg[2];  vy_reg[2]  <= vy_reg[1];
                    col_reg[1] <= col_reg[2]; col_reg[2] <= col_reg[1];
                end
            end
            ST_BOX:
            begin
                x0_reg   <= lox[15] ? '0 : XW'(lox[15:4]);
                y0_reg   <= loy[15] ? '0 : YW'(loy[15:4]);
                x1_reg   <= (17'(hix) >= limx) ? XW'(actw_reg - 7'd1) : XW'(hix[15:4]);
                y1_reg   <= (17'(hiy) >= limy) ? YW'(acth_reg - 7'd1) : YW'(hiy[15:4]);
                cx_reg   <= lox[15] ? '0 : XW'(lox[15:4]);
                cy_reg   <= loy[15] ? '0 : YW'(loy[15:4]);
                ci_reg   <= '0;
                cj_reg   <= '0;
                step_reg <= '0;
                for (int n = 0; n < 3; n++)
                begin
                    px_reg[n] <= px_c[n];
                    py_reg[n] <= py_c[n];
                    ex_reg[n] <= px_c[(n + 1) % 3] - px_c[n];
                    ey_reg[n] <= py_c[(n + 1) % 3] - py_c[n];
                end
            end
            ST_SETUP:
            begin
                step_reg <= step_reg + 4'd1;
                if (step_reg[0])
                    first_reg <= prod_reg;
                case (step_reg)
                    4'd2: d_reg <= sum_now;
                    4'd4: begin erow_reg[0] <= sum_now; ecur_reg[0] <= sum_now; end
                    4'd6: begin erow_reg[1] <= sum_now; ecur_reg[1] <= sum_now; end
                    4'd8: begin erow_reg[2] <= sum_now; ecur_reg[2] <= sum_now; end
                    4'd10:
                    begin
                        vnrow_reg <= sum_now;
                        vncur_reg <= sum_now;
                        dd_reg    <= d_reg[EDGE_W-1] ? -d_reg : d_reg;
                    end
                    default: ;
                endcase
            end
            ST_SCAN:
            begin
                if (covered && blend_en)
                begin
                    u_reg  <= BARY_W'(dd_reg) - BARY_W'(vn_s) - BARY_W'(wn_s);
                    v_reg  <= BARY_W'(vn_s);
                    w_reg  <= BARY_W'(wn_s);
                    mb_reg <= 3'd7;
                    for (int c = 0; c < 3; c++)
                        acc_reg[c] <= '0;
                end
                else
                begin
                    cx_reg <= cx_adv; cy_reg <= cy_adv;
                    ci_reg <= ci_adv; cj_reg <= cj_adv;
                    ecur_reg  <= ecur_adv;
                    erow_reg  <= erow_adv;
                    vncur_reg <= vncur_adv;
                    vnrow_reg <= vnrow_adv;
                end
            end
            ST_MUL:
            begin
                // Shift-add of the weights by the colour bits, MSB first
                mb_reg <= mb_reg - 3'd1;
                for (int c = 0; c < 3; c++)
                    acc_reg[c] <= (acc_reg[c] <<< 1)
                        + (chan_bit(col_reg[0], c, mb_reg) ? NUM_W'(u_reg) : '0)
                        + (chan_bit(col_reg[1], c, mb_reg) ? NUM_W'(v_reg) : '0)
                        + (chan_bit(col_reg[2], c, mb_reg) ? NUM_W'(w_reg) : '0);
            end
            ST_CLAMP:
            begin
                // Clamp to 0..255 of the area, then round to nearest
                for (int c = 0; c < 3; c++)
                begin
                    if (acc_reg[c][NUM_W-1])
                        rem_reg[c] <= DIV_W'(dd_reg);
                    else if (acc_reg[c] > lim_n)
                        rem_reg[c] <= DIV_W'(lim_n <<< 1) + DIV_W'(dd_reg);
                    else
                        rem_reg[c] <= DIV_W'(acc_reg[c] <<< 1) + DIV_W'(dd_reg);
                    q_reg[c] <= '0;
                end
                dsh_reg <= DIV_W'(dd_reg) << 8;
                db_reg  <= 3'd7;
            end
            ST_DIV:
            begin
                db_reg  <= db_reg - 3'd1;
                dsh_reg <= dsh_reg >> 1;
                rem_reg <= rem_next;
                q_reg   <= q_next;
                if (db_reg == 3'd0 && res_mode_reg)
                begin
                    red_reg   <= q_next[0];
                    green_reg <= q_next[1];
                    blue_reg  <= q_next[2];
                end
            end
            ST_WRITE:
            begin
                cx_reg <= cx_adv; cy_reg <= cy_adv;
                ci_reg <= ci_adv; cj_reg <= cj_adv;
                ecur_reg  <= ecur_adv;
                erow_reg  <= erow_adv;
                vncur_reg <= vncur_adv;
                vnrow_reg <= vnrow_adv;
            end
            ST_POINT:
                s_reg <= s_reg + CW'(1);
            ST_ACC:
            begin
                s_reg   <= s_reg + CW'(1);
                sum_reg <= sum_next;
                for (int c = 0; c < 3; c++)
                begin
                    rem_reg[c] <= DIV_W'(sum_next[c]);
                    q_reg[c]   <= '0;
                end
                dsh_reg <= DIV_W'(cnt) << 7;
                db_reg  <= 3'd7;
            end
            default: ;
        endcase
    end

endmodule
